### hw/rtl/cru_pkg.sv
// Shared types and constants for the combinadic rank/unrank block.
// Holds the operation code and the command and status bundles between the
// controller and the datapath. Depends on nothing.
`timescale 1ns / 1ps

package cru_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int DATA_W = 64;
	localparam int SIZE_W = 6;

	typedef enum logic {
		OP_RANK   = 1'b0,
		OP_UNRANK = 1'b1
	} cru_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic fill_rd;
		logic fill_wr;
		logic load;
		logic rank_step;
		logic ur_check_rd;
		logic ur_set_err;
		logic ur_fill_low;
		logic ur_skip;
		logic ur_probe_rd;
		logic ur_probe_cmp;
		logic rsp_load;
	} cru_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fill_last;
		logic rank_last;
		logic ur_bad;
		logic ur_over;
		logic i_zero;
		logic rem_zero;
		logic pos_zero;
		logic rsp_free;
	} cru_sts_t;

endpackage

### hw/rtl/cru_if.sv
// Valid/ready channel interfaces for requests and responses of the
// combinadic rank/unrank block. Depends on cru_pkg for field widths.
`timescale 1ns / 1ps

interface cru_req_if;
	logic                        valid;
	logic                        ready;
	logic                        operation;
	logic [cru_pkg::DATA_W-1:0]  member_mask;
	logic [cru_pkg::DATA_W-1:0]  rank_value;
	logic [cru_pkg::SIZE_W-1:0]  subset_size;
	logic [cru_pkg::SIZE_W-1:0]  set_size;

	modport source(output valid, output operation, output member_mask, output rank_value,
		output subset_size, output set_size, input ready);
	modport sink(input valid, input operation, input member_mask, input rank_value,
		input subset_size, input set_size, output ready);
endinterface

interface cru_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [cru_pkg::DATA_W-1:0]  rank_out;
	logic [cru_pkg::DATA_W-1:0]  mask_out;
	logic                        error;

	modport source(output valid, output rank_out, output mask_out, output error,
		input ready);
	modport sink(input valid, input rank_out, input mask_out, input error,
		output ready);
endinterface

### hw/rtl/combinadic_rank_unrank.sv
// Combinadic rank/unrank, one request in work at a time and one response beat per request.
// Rank: after acceptance, a table read per mask position, then one add and the response load.
// Unrank: a bounds check, a range check against C(n,k), a downward scan, then the response load.
// A new request is taken only when idle, in the cycle after the response loads; the response
// load itself waits until the response register is free, so a stalled sink holds the flow.
// Reset: the table is built first, a read and a write per entry, with ready low.
`timescale 1ns / 1ps

module combinadic_rank_unrank #(
	parameter int MAX_ELEMENTS = cru_pkg::MAX_ELEMENTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	cru_req_if.sink    req,
	cru_rsp_if.source  rsp
);

	// The controller owns sequencing; the datapath owns the table memory and all
	// arithmetic. They talk only through the command and status bundles.
	cru_pkg::cru_cmd_t cmd;
	cru_pkg::cru_sts_t sts;

	// A request beat is taken only in the idle state, so the datapath may load
	// its working registers straight from the channel on that cycle. The response
	// register sits behind the controller, so a new request can be accepted while
	// the previous response beat is still waiting on the sink.
	cru_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start_valid (req.valid),
		.start_op    (cru_pkg::cru_op_t'(req.operation)),
		.ready       (req.ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	cru_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (req.operation),
		.member_mask (req.member_mask),
		.rank_value  (req.rank_value),
		.subset_size (req.subset_size),
		.set_size    (req.set_size),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rank_out    (rsp.rank_out),
		.mask_out    (rsp.mask_out),
		.error       (rsp.error)
	);

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in work");

	// A flagged unrank carries neither a mask nor a rank.
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.error) |-> (rsp.mask_out == '0 && rsp.rank_out == '0))
		else $error("error response with nonzero payload");

	// A rank response never carries a mask.
	a_rank_no_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.rank_out != '0) |-> (rsp.mask_out == '0 && !rsp.error))
		else $error("rank response with mask or error set");

endmodule

### hw/rtl/cru_dp.sv
// Datapath of the combinadic rank/unrank block: binomial table memory,
// fill sweep, rank accumulator, unrank scan registers and response register.
// Depends on cru_pkg for the command and status bundles.
`timescale 1ns / 1ps

module cru_dp #(
	parameter int MAX_ELEMENTS = cru_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cru_pkg::cru_cmd_t          cmd,
	output cru_pkg::cru_sts_t          sts,
	input  logic                       operation,
	input  logic [cru_pkg::DATA_W-1:0] member_mask,
	input  logic [cru_pkg::DATA_W-1:0] rank_value,
	input  logic [cru_pkg::SIZE_W-1:0] subset_size,
	input  logic [cru_pkg::SIZE_W-1:0] set_size,
	input  logic                       rsp_ready,
	output logic                       rsp_valid,
	output logic [cru_pkg::DATA_W-1:0] rank_out,
	output logic [cru_pkg::DATA_W-1:0] mask_out,
	output logic                       error
);

	localparam int DW    = cru_pkg::DATA_W;
	localparam int SW    = cru_pkg::SIZE_W;
	localparam int COLS  = (MAX_ELEMENTS + 1) / 2;
	localparam int DEPTH = MAX_ELEMENTS * COLS;
	localparam int AW    = $clog2(DEPTH);
	localparam int RW    = $clog2(MAX_ELEMENTS);
	localparam int CW    = $clog2(COLS);

	function automatic logic [AW-1:0] tab_addr(input logic [RW-1:0] row,
		input logic [CW-1:0] col);
		return AW'(row) * AW'(COLS) + AW'(col);
	endfunction

	// Column folded by symmetry; the result is used only where col <= row, and callers discard reads with col > row.
	function automatic logic [CW-1:0] fold_col(input logic [RW-1:0] row,
		input logic [SW-1:0] col);
		logic [SW:0] r_w;
		logic [SW:0] c_w;
		logic [SW:0] d_w;
		r_w = (SW+1)'(row);
		c_w = (SW+1)'(col);
		d_w = r_w - c_w;
		return (d_w < c_w) ? CW'(d_w) : CW'(c_w);
	endfunction

	logic [DW-1:0]      mem [DEPTH];
	logic [DW-1:0]      rdata_q;
	logic [AW-1:0]      raddr;
	logic [AW-1:0]      waddr;
	logic [DW-1:0]      wdata;
	logic               re;

	logic [RW-1:0]      fill_row_q;
	logic [CW-1:0]      fill_col_q;
	logic [DW-1:0]      fill_prev_q;
	logic [RW-1:0]      fill_src_row;

	cru_pkg::cru_op_t   op_q;
	logic [DW-1:0]      scan_mask_q;
	logic [RW-1:0]      p_q;
	logic [SW:0]        j_q;
	logic [SW:0]        j_next;
	logic               rank_hit;
	logic               hit_s1;
	logic [DW-1:0]      sum_q;

	logic [DW-1:0]      rem_q;
	logic [SW-1:0]      i_q;
	logic [SW-1:0]      n_q;
	logic [RW-1:0]      pos_q;
	logic [DW-1:0]      res_mask_q;
	logic               err_q;
	logic               zero_s1;
	logic [DW-1:0]      probe_b;
	logic               probe_take;

	logic               rsp_valid_q;
	logic [DW-1:0]      rank_out_q;
	logic [DW-1:0]      mask_out_q;
	logic               error_q;

	// Rank scan: the next set bit, counted from one, selects the column.
	assign j_next   = j_q + (SW+1)'(scan_mask_q[0]);
	assign rank_hit = scan_mask_q[0] && (j_next <= (SW+1)'(p_q));

	assign fill_src_row = (fill_row_q == '0) ? '0 : fill_row_q - 1'b1;

	always_comb begin
		if (cmd.fill_rd) begin
			raddr = tab_addr(fill_src_row, fill_col_q);
		end else if (cmd.rank_step) begin
			raddr = tab_addr(p_q, fold_col(p_q, j_next[SW-1:0]));
		end else if (cmd.ur_check_rd) begin
			raddr = tab_addr(RW'(n_q), fold_col(RW'(n_q), i_q));
		end else begin
			raddr = tab_addr(pos_q, fold_col(pos_q, i_q));
		end
	end

	assign re = cmd.fill_rd | cmd.rank_step | cmd.ur_check_rd | cmd.ur_probe_rd;
	assign waddr = tab_addr(fill_row_q, fill_col_q);

	always_comb begin
		if (fill_col_q == '0) begin
			wdata = DW'(1);
		end else if (fill_row_q == '0) begin
			wdata = '0;
		end else begin
			wdata = rdata_q + fill_prev_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_wr) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign probe_b    = zero_s1 ? '0 : rdata_q;
	assign probe_take = rem_q >= probe_b;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_row_q  <= '0;
			fill_col_q  <= '0;
			hit_s1      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_wr) begin
				if (fill_col_q == CW'(COLS - 1)) begin
					fill_col_q <= '0;
					fill_row_q <= fill_row_q + 1'b1;
				end else begin
					fill_col_q <= fill_col_q + 1'b1;
				end
			end
			hit_s1 <= cmd.rank_step && rank_hit;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cmd.fill_wr) begin
			fill_prev_q <= (fill_col_q == '0) ? DW'(1) : rdata_q;
		end
		if (cmd.load) begin
			op_q        <= cru_pkg::cru_op_t'(operation);
			scan_mask_q <= member_mask;
			p_q         <= '0;
			j_q         <= '0;
			sum_q       <= '0;
			rem_q       <= rank_value;
			i_q         <= subset_size;
			n_q         <= set_size;
			pos_q       <= RW'(set_size);
			res_mask_q  <= '0;
			err_q       <= 1'b0;
		end
		if (cmd.rank_step) begin
			scan_mask_q <= scan_mask_q >> 1;
			p_q         <= p_q + 1'b1;
			j_q         <= j_next;
		end
		if (hit_s1) begin
			sum_q <= sum_q + rdata_q;
		end
		if (cmd.ur_set_err) begin
			err_q <= 1'b1;
		end
		if (cmd.ur_probe_rd) begin
			zero_s1 <= i_q > SW'(pos_q);
		end
		if (cmd.ur_fill_low) begin
			res_mask_q <= res_mask_q | (DW'(1) << SW'(i_q - 1'b1));
			i_q        <= i_q - 1'b1;
		end
		if (cmd.ur_skip) begin
			i_q <= i_q - 1'b1;
		end
		if (cmd.ur_probe_cmp) begin
			pos_q <= pos_q - 1'b1;
			if (probe_take) begin
				res_mask_q <= res_mask_q | (DW'(1) << pos_q);
				rem_q      <= rem_q - probe_b;
				i_q        <= i_q - 1'b1;
			end
		end
		if (cmd.rsp_load) begin
			rank_out_q <= (op_q == cru_pkg::OP_RANK) ? sum_q : '0;
			mask_out_q <= (op_q == cru_pkg::OP_UNRANK && !err_q) ? res_mask_q : '0;
			error_q    <= (op_q == cru_pkg::OP_UNRANK) && err_q;
		end
	end

	assign sts.fill_last = (fill_row_q == RW'(MAX_ELEMENTS - 1)) &&
		(fill_col_q == CW'(COLS - 1));
	assign sts.rank_last = p_q == RW'(MAX_ELEMENTS - 1);
	assign sts.ur_bad    = (i_q > n_q) || ((SW+1)'(n_q) >= (SW+1)'(MAX_ELEMENTS));
	assign sts.ur_over   = rem_q >= rdata_q;
	assign sts.i_zero    = i_q == '0;
	assign sts.rem_zero  = rem_q == '0;
	assign sts.pos_zero  = pos_q == '0;
	assign sts.rsp_free  = !rsp_valid_q || rsp_ready;

	assign rsp_valid = rsp_valid_q;
	assign rank_out  = rank_out_q;
	assign mask_out  = mask_out_q;
	assign error     = error_q;

endmodule

### hw/rtl/cru_ctrl.sv
// Controller of the combinadic rank/unrank block: sequences the table fill,
// the rank scan and the unrank search. Depends on cru_pkg.
`timescale 1ns / 1ps

module cru_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start_valid,
	input  cru_pkg::cru_op_t  start_op,
	output logic              ready,
	input  cru_pkg::cru_sts_t sts,
	output cru_pkg::cru_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_FILL_RD,
		S_FILL_WR,
		S_IDLE,
		S_RANK_SCAN,
		S_RANK_DRAIN,
		S_UR_CHECK,
		S_UR_RANGE,
		S_UR_STEP,
		S_UR_PROBE,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;

	assign ready = state_q == S_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_FILL_RD: begin
				cmd.fill_rd = 1'b1;
				state_d     = S_FILL_WR;
			end
			S_FILL_WR: begin
				cmd.fill_wr = 1'b1;
				state_d     = sts.fill_last ? S_IDLE : S_FILL_RD;
			end
			S_IDLE: begin
				if (start_valid) begin
					cmd.load = 1'b1;
					state_d  = (start_op == cru_pkg::OP_UNRANK) ? S_UR_CHECK : S_RANK_SCAN;
				end
			end
			S_RANK_SCAN: begin
				cmd.rank_step = 1'b1;
				if (sts.rank_last) begin
					state_d = S_RANK_DRAIN;
				end
			end
			S_RANK_DRAIN: begin
				state_d = S_DONE;
			end
			S_UR_CHECK: begin
				if (sts.ur_bad) begin
					cmd.ur_set_err = 1'b1;
					state_d        = S_DONE;
				end else begin
					cmd.ur_check_rd = 1'b1;
					state_d         = S_UR_RANGE;
				end
			end
			S_UR_RANGE: begin
				if (sts.ur_over) begin
					cmd.ur_set_err = 1'b1;
					state_d        = S_DONE;
				end else begin
					state_d = S_UR_STEP;
				end
			end
			S_UR_STEP: begin
				if (sts.i_zero) begin
					state_d = S_DONE;
				end else if (sts.rem_zero) begin
					cmd.ur_fill_low = 1'b1;
				end else if (sts.pos_zero) begin
					cmd.ur_skip = 1'b1;
				end else begin
					cmd.ur_probe_rd = 1'b1;
					state_d         = S_UR_PROBE;
				end
			end
			S_UR_PROBE: begin
				cmd.ur_probe_cmp = 1'b1;
				state_d          = S_UR_STEP;
			end
			S_DONE: begin
				if (sts.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL_RD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### tb/sv/combinadic_rank_unrank_test.sv
// Self-checking testbench for combinadic_rank_unrank: directed and random rank and
// unrank beats against an in-bench binomial-table predictor and scoreboard class.
// Depends on cru_pkg, the cru_req_if/cru_rsp_if interfaces and the block itself.
`timescale 1ns / 1ps

module combinadic_rank_unrank_test;

	localparam int DATA_W = cru_pkg::DATA_W;
	localparam int SIZE_W = cru_pkg::SIZE_W;
	localparam int ELEMENTS = cru_pkg::MAX_ELEMENTS_DEF;
	localparam int COLS = (ELEMENTS + 1) / 2;
	localparam int RANDOM_BEATS = 1100;

	// One request beat as the sender sees it.
	typedef struct {
		cru_pkg::cru_op_t  operation;
		logic [DATA_W-1:0] member_mask;
		logic [DATA_W-1:0] rank_value;
		logic [SIZE_W-1:0] subset_size;
		logic [SIZE_W-1:0] set_size;
	} request_t;

	// One response beat: what the block should return for a request.
	typedef struct {
		logic [DATA_W-1:0] rank_out;
		logic [DATA_W-1:0] mask_out;
		logic              error;
	} conversion_t;

	// Receiver behavior, switched after a random stretch.
	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_PERIODIC,
		RX_SPARSE
	} rx_mode_t;

	// The scoreboard keeps its own Pascal table and the queue of conversions
	// still owed by the block, oldest first.
	class combinadic_checker;
		bit [DATA_W-1:0] pascal [ELEMENTS][COLS];
		conversion_t owed_conversions[$];
		int unsigned failures;

		function new();
			for (int c = 0; c < COLS; c++)
				pascal[0][c] = (c == 0) ? 64'd1 : 64'd0;
			for (int r = 1; r < ELEMENTS; r++) begin
				pascal[r][0] = 64'd1;
				for (int c = 1; c < COLS; c++)
					pascal[r][c] = pascal[r-1][c] + pascal[r-1][c-1];
			end
			failures = 0;
		endfunction

		// C(r,c) read through the half-width table by symmetry.
		function bit [DATA_W-1:0] binomial(int unsigned r, int unsigned c);
			if (c > r || r >= ELEMENTS)
				return '0;
			if (r - c < c)
				c = r - c;
			if (c >= COLS)
				return '0;
			return pascal[r][c];
		endfunction

		function conversion_t convert(request_t q);
			conversion_t x;
			bit [DATA_W-1:0] remaining;
			bit [DATA_W-1:0] b;
			int unsigned j;
			int pos;
			bit placed;
			x.rank_out = '0;
			x.mask_out = '0;
			x.error = 1'b0;
			if (q.operation == cru_pkg::OP_RANK) begin
				j = 0;
				for (int p = 0; p < ELEMENTS; p++) begin
					if (q.member_mask[p]) begin
						j++;
						x.rank_out += binomial(p, j);
					end
				end
			end else if (q.subset_size > q.set_size || q.set_size >= ELEMENTS ||
					q.rank_value >= binomial(q.set_size, q.subset_size)) begin
				x.error = 1'b1;
			end else begin
				remaining = q.rank_value;
				pos = q.set_size;
				for (int i = q.subset_size; i >= 1; i--) begin
					if (remaining == 0) begin
						x.mask_out[i-1] = 1'b1;
					end else begin
						placed = 1'b0;
						while (pos >= 1 && !placed) begin
							b = binomial(pos, i);
							if (remaining >= b) begin
								x.mask_out[pos] = 1'b1;
								remaining -= b;
								placed = 1'b1;
							end
							pos--;
						end
					end
				end
			end
			return x;
		endfunction

		function void accept_request(request_t q);
			owed_conversions = {owed_conversions, convert(q)};
		endfunction

		function void report(string what, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
			$display("%0t: %s expected %h actual %h", $time, what, want, got);
			failures++;
		endfunction

		function void check_result(logic [DATA_W-1:0] rank_out, logic [DATA_W-1:0] mask_out,
				logic error);
			conversion_t x;
			if (owed_conversions.size() == 0) begin
				$display("%0t: unexpected response, rank_out %h mask_out %h error %b",
					$time, rank_out, mask_out, error);
				failures++;
				return;
			end
			x = owed_conversions.pop_front();
			if (x.rank_out !== rank_out)
				report("rank_out", x.rank_out, rank_out);
			if (x.mask_out !== mask_out)
				report("mask_out", x.mask_out, mask_out);
			if (x.error !== error)
				report("error", {63'd0, x.error}, {63'd0, error});
		endfunction

		function int pending();
			return owed_conversions.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sink_ready = 1'b0;

	cru_req_if req ();
	cru_rsp_if rsp ();

	combinadic_rank_unrank u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	combinadic_checker board = new();

	// Sender pacing: a burst of back-to-back beats, then at times a gap.
	int unsigned burst_left = 0;

	// Receiver pattern state.
	rx_mode_t rx_mode = RX_OPEN;
	int unsigned rx_mode_left = 100;
	int unsigned rx_phase = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	assign rsp.ready = sink_ready;

	// Receiver: check every response beat taken at this edge, then choose the
	// ready level for the next edge. Each mode stays for a random stretch, so
	// some stretches never stall and others stall heavily or periodically.
	always @(posedge clk) begin
		if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
			board.check_result(rsp.rank_out, rsp.mask_out, rsp.error);
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_mode_left <= $urandom_range(32, 300);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		rx_phase <= rx_phase + 1;
		case (rx_mode)
			RX_OPEN: sink_ready <= 1'b1;
			RX_COIN: sink_ready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: sink_ready <= (rx_phase % 5) < 2;
			default: sink_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic request_t make_req(cru_pkg::cru_op_t op, logic [DATA_W-1:0] mask,
			logic [DATA_W-1:0] rank, int unsigned k, int unsigned n);
		request_t q;
		q.operation = op;
		q.member_mask = mask;
		q.rank_value = rank;
		q.subset_size = k[SIZE_W-1:0];
		q.set_size = n[SIZE_W-1:0];
		return q;
	endfunction

	function automatic logic [DATA_W-1:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Presents one request beat and returns at the edge where it is accepted.
	// Must be called at a rising edge. Before the beat, the sender may close
	// its current burst and sit idle for a while with valid low; valid is
	// never lowered and raised within the same edge.
	task automatic send_request(input request_t q);
		int unsigned gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 9);
			case ($urandom_range(0, 15))
				0, 1, 2, 3: gap = 0;
				4: gap = $urandom_range(20, 200);
				default: gap = $urandom_range(1, 12);
			endcase
			if (gap != 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req.valid <= 1'b1;
		req.operation <= q.operation;
		req.member_mask <= q.member_mask;
		req.rank_value <= q.rank_value;
		req.subset_size <= q.subset_size;
		req.set_size <= q.set_size;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		board.accept_request(q);
	endtask

	// Random rank beat: masks range from sparse to dense; the unused unrank
	// fields carry noise, since the block must ignore them.
	function automatic request_t random_rank();
		logic [DATA_W-1:0] mask;
		case ($urandom_range(0, 3))
			0: mask = random_word();
			1: mask = random_word() & random_word() & random_word();
			2: mask = random_word() | random_word();
			default: begin
				mask = '0;
				repeat ($urandom_range(1, 4))
					mask[$urandom_range(0, 63)] = 1'b1;
			end
		endcase
		return make_req(cru_pkg::OP_RANK, mask, random_word(), $urandom_range(0, 63),
			$urandom_range(0, 63));
	endfunction

	// Random unrank beat: mostly in range, so the downward scan and the
	// zero-remainder fill both get exercised, with some k > n and some ranks
	// at or above C(n,k).
	function automatic request_t random_unrank();
		int unsigned n;
		int unsigned k;
		logic [DATA_W-1:0] limit;
		logic [DATA_W-1:0] rank;
		case ($urandom_range(0, 7))
			0: begin
				n = $urandom_range(0, 62);
				k = $urandom_range(n + 1, 63);
				rank = ($urandom_range(0, 1) == 0) ? '0 : random_word();
			end
			1: begin
				n = $urandom_range(0, 63);
				k = $urandom_range(0, n);
				limit = board.binomial(n, k);
				rank = ($urandom_range(0, 1) == 0) ? limit + $urandom_range(0, 3) :
					random_word();
				if (rank < limit)
					rank = limit;
			end
			default: begin
				n = ($urandom_range(0, 1) == 0) ? $urandom_range(40, 63) : $urandom_range(0, 63);
				k = $urandom_range(0, n);
				limit = board.binomial(n, k);
				case ($urandom_range(0, 3))
					0: rank = limit - 1 - (64'($urandom_range(0, 7)) % limit);
					1: rank = 64'($urandom_range(0, 15)) % limit;
					default: rank = random_word() % limit;
				endcase
			end
		endcase
		return make_req(cru_pkg::OP_UNRANK, random_word(), rank, k, n);
	endfunction

	initial begin
		request_t directed[$];
		logic [DATA_W-1:0] c_63_31;
		c_63_31 = board.binomial(63, 31);

		req.valid <= 1'b0;
		req.operation <= cru_pkg::OP_RANK;
		req.member_mask <= '0;
		req.rank_value <= '0;
		req.subset_size <= '0;
		req.set_size <= '0;

		// Reset is held low at the start; the block then builds its table and
		// will not raise ready until that is done.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Ranking: empty mask, full mask, single elements at both ends, the
		// upper half, alternating patterns, and noise on the unrank fields.
		directed = {directed, make_req(cru_pkg::OP_RANK, 64'h0, 64'h0, 0, 0)};
		directed = {directed, make_req(cru_pkg::OP_RANK, '1, '1, 63, 63)};
		directed = {directed, make_req(cru_pkg::OP_RANK, 64'h8000_0000_0000_0000, 64'h0, 0, 0)};
		directed = {directed, make_req(cru_pkg::OP_RANK, 64'h0000_0000_0000_0001, '1, 63, 0)};
		directed = {directed, make_req(cru_pkg::OP_RANK, 64'hFFFF_FFFF_0000_0000, 64'h0, 0, 0)};
		directed = {directed, make_req(cru_pkg::OP_RANK, 64'hAAAA_AAAA_AAAA_AAAA, 64'h0, 0, 0)};
		directed = {directed, make_req(cru_pkg::OP_RANK, 64'h5555_5555_5555_5555, 64'h0, 0, 0)};
		directed = {directed, make_req(cru_pkg::OP_RANK, 64'h8000_0000_0000_0001, 64'h0, 0, 0)};
		// Unranking: empty subsets, with a valid and an invalid rank.
		directed = {directed, make_req(cru_pkg::OP_UNRANK, '1, 64'h0, 0, 0)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'h0, 0, 63)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'h1, 0, 5)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, '1, 0, 63)};
		// Subset larger than the set.
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'h0, 1, 0)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'h0, 63, 62)};
		// Whole set chosen: the remainder is zero from the start.
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'h0, 63, 63)};
		// Largest table entry: top rank in range, first rank out of range.
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, c_63_31 - 1, 31, 63)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, c_63_31, 31, 63)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, '1, 32, 63)};
		// Single and near-full subsets at the top of the set, then the lowest and highest rank of three from ten.
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'd62, 1, 63)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'd62, 62, 63)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'd63, 62, 63)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'h0, 3, 10)};
		directed = {directed, make_req(cru_pkg::OP_UNRANK, 64'h0, 64'd119, 3, 10)};

		@(posedge clk);
		foreach (directed[d])
			send_request(directed[d]);

		for (int b = 0; b < RANDOM_BEATS; b++) begin
			if ($urandom_range(0, 9) < 4)
				send_request(random_rank());
			else
				send_request(random_unrank());
		end
		req.valid <= 1'b0;

		// Drain, then give the block time to show any stray response beat.
		while (board.pending() != 0)
			@(posedge clk);
		repeat (250) @(posedge clk);

		if (board.failures == 0 && board.pending() == 0)
			$display("combinadic_rank_unrank_test: clean");
		else
			$display("combinadic_rank_unrank_test: errors");
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest correct run,
	// including the table build after reset.
	initial begin
		#40_000_000;
		$display("combinadic_rank_unrank_test: errors");
		$finish;
	end

endmodule

### sim.f
hw/rtl/cru_pkg.sv
hw/rtl/cru_if.sv
hw/rtl/cru_dp.sv
hw/rtl/cru_ctrl.sv
hw/rtl/combinadic_rank_unrank.sv
tb/sv/combinadic_rank_unrank_test.sv
